// ----- hdl/best_address_tracker_macros.svh -----
// Assertion helpers for the best address tracker.
`ifndef BEST_ADDRESS_TRACKER_MACROS_SVH
`define BEST_ADDRESS_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BAT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BAT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bat_pkg.sv -----
package bat_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    // Global unicast test on the top 16 address bits (2000::/3)
    localparam logic [15:0] GLOBAL_MASK  = 16'hE000;
    localparam logic [15:0] GLOBAL_VALUE = 16'h2000;

    localparam logic [31:0] INF_LIFETIME = 32'hFFFF_FFFF;
    localparam logic [32:0] INF_SECONDS  = 33'(100 * 86400);

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [32:0] expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_REPORT
    } state_t;

endpackage

// ----- hdl/bat_ram.sv -----
module bat_ram
    import bat_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/best_address_tracker.sv -----
// Best address tracker. An event is taken at a clock edge with start high and
// busy low; one result follows per event, shown for a single cycle with done
// high, and it cannot be held off, so the receiver must take it then. The
// table lives in one single-port-write, registered-read RAM and is walked once
// per global event: that one pass finds and removes the matching entry (later
// entries move down one slot), and tracks the largest expiry among the
// survivors; the new entry, if any, is appended after the pass. An event for
// a global address goes through the scan, which issues one RAM read per entry
// held before the event (up to TABLE_DEPTH) and lets the last read drain, then
// through an append step and a report step. An event outside 2000::/3 skips
// the scan and the append and goes straight to report. busy drops in the
// done cycle, so the next transfer can be accepted while the result is being
// shown. best_high and best_low change only with a done strobe; stored_count
// updates in the cycle before the strobe and then holds until the next event's
// append cycle.
module best_address_tracker
    import bat_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [63:0] addr_high,
    input  logic [63:0] addr_low,
    input  logic        unusable,
    input  logic [31:0] now_seconds,
    input  logic        has_lifetime,
    input  logic [31:0] preferred_lifetime,
    output logic        done,
    output logic        best_changed,
    output logic [63:0] best_high,
    output logic [63:0] best_low,
    output logic [4:0]  stored_count,
    output logic        table_overflow
);

`include "best_address_tracker_macros.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    // latched event
    logic [63:0] hi_reg, lo_reg;
    logic        add_ok_reg;
    logic [32:0] exp_reg;

    // table control
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] iss_reg;      // next entry to read
    logic             rx_vld_reg;   // read data valid this cycle
    logic [IDX_W-1:0] rx_idx_reg;   // index of that read data
    logic             matched_reg;  // matching entry already passed

    // running maximum
    logic        have_reg;
    logic [32:0] pick_exp_reg;
    logic [63:0] pick_hi_reg, pick_lo_reg;

    // best and result
    logic [63:0] best_hi_reg, best_lo_reg;
    logic        done_reg, changed_reg, overflow_reg;

    // RAM side
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_bits;

    logic             issue;
    logic             hit;
    logic             take_rd;
    logic [CNT_W-1:0] cnt_after;
    logic             room;
    logic             do_append;
    logic             is_global;
    logic [32:0]      exp_calc;
    logic             new_best;

    assign rd_entry  = entry_t'(rd_bits);
    assign is_global = (addr_high[63:48] & GLOBAL_MASK) == GLOBAL_VALUE;

    always_comb
    begin
        exp_calc = {1'b0, now_seconds};
        if (has_lifetime)
        begin
            if (preferred_lifetime == INF_LIFETIME)
            begin
                exp_calc = exp_calc + INF_SECONDS;
            end
            else
            begin
                exp_calc = exp_calc + {1'b0, preferred_lifetime};
            end
        end
    end

    // scan datapath terms
    assign issue   = (state_reg == ST_SCAN) && (iss_reg < count_reg);
    assign hit     = rx_vld_reg && !matched_reg
                     && (rd_entry.addr_high == hi_reg) && (rd_entry.addr_low == lo_reg);
    assign take_rd = rx_vld_reg && !hit
                     && (!have_reg || (rd_entry.expiry > pick_exp_reg));

    // append terms
    assign cnt_after = count_reg - CNT_W'(matched_reg);
    assign room      = cnt_after < CNT_FULL;
    assign do_append = (state_reg == ST_APPEND) && add_ok_reg && room;

    // empty table keeps the old best
    assign new_best  = have_reg && (pick_hi_reg != best_hi_reg || pick_lo_reg != best_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and RAM write control
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = rx_idx_reg - IDX_W'(1);
        ram_wdata  = rd_entry;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = is_global ? ST_SCAN : ST_REPORT;
                end
            end
            ST_SCAN:
            begin
                // entries past the match move down one slot
                ram_we = rx_vld_reg && matched_reg;
                if (!issue && !rx_vld_reg)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                ram_we     = do_append;
                ram_waddr  = cnt_after[IDX_W-1:0];
                ram_wdata  = '{addr_high: hi_reg, addr_low: lo_reg, expiry: exp_reg};
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            iss_reg      <= '0;
            rx_vld_reg   <= 1'b0;
            matched_reg  <= 1'b0;
            have_reg     <= 1'b0;
            best_hi_reg  <= '0;
            best_lo_reg  <= '0;
            done_reg     <= 1'b0;
            changed_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= (state_reg == ST_REPORT);
            rx_vld_reg <= issue;
            if (issue)
            begin
                iss_reg <= iss_reg + CNT_W'(1);
            end
            if (state_reg == ST_IDLE && start)
            begin
                iss_reg      <= '0;
                matched_reg  <= 1'b0;
                have_reg     <= 1'b0;
                overflow_reg <= 1'b0;
            end
            if (hit)
            begin
                matched_reg <= 1'b1;
            end
            if (take_rd || (do_append && (!have_reg || exp_reg > pick_exp_reg)))
            begin
                have_reg <= 1'b1;
            end
            if (state_reg == ST_APPEND)
            begin
                count_reg    <= cnt_after + CNT_W'(do_append);
                overflow_reg <= add_ok_reg && !room;
            end
            if (state_reg == ST_REPORT)
            begin
                changed_reg <= new_best;
                if (new_best)
                begin
                    best_hi_reg <= pick_hi_reg;
                    best_lo_reg <= pick_lo_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            hi_reg     <= addr_high;
            lo_reg     <= addr_low;
            add_ok_reg <= mode && !unusable;
            exp_reg    <= exp_calc;
        end
        if (issue)
        begin
            rx_idx_reg <= iss_reg[IDX_W-1:0];
        end
        // strict compare: earliest entry wins a tie
        if (take_rd)
        begin
            pick_exp_reg <= rd_entry.expiry;
            pick_hi_reg  <= rd_entry.addr_high;
            pick_lo_reg  <= rd_entry.addr_low;
        end
        else if (do_append && (!have_reg || exp_reg > pick_exp_reg))
        begin
            pick_exp_reg <= exp_reg;
            pick_hi_reg  <= hi_reg;
            pick_lo_reg  <= lo_reg;
        end
    end

    bat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (rd_bits)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign best_changed   = changed_reg;
    assign best_high      = best_hi_reg;
    assign best_low       = best_lo_reg;
    assign stored_count   = 5'(count_reg);
    assign table_overflow = overflow_reg;

    `BAT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_FULL, "entry count above depth")
    `BAT_ASSERT_IMP(a_shift_after_match, (state_reg == ST_SCAN) && ram_we, matched_reg,
        "table shift before any match")
    `BAT_ASSERT_IMP(a_overflow_full, done && table_overflow, count_reg == CNT_FULL,
        "overflow reported with room left")
    `BAT_ASSERT_IMP(a_change_nonempty, done && best_changed, count_reg != '0,
        "best changed on empty table")
    `BAT_ASSERT_NXT(a_report_done, state_reg == ST_REPORT, done && !busy,
        "report not followed by done")

endmodule
